>>> hw/rtl/ccs_pkg.sv
// Shared types and character constants for the C comment stripper.
package ccs_pkg;

    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_result;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } t_item;

endpackage

>>> hw/rtl/ccs_stream_if.sv
// Valid/ready stream interfaces for the input and result channels.
interface ccs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface ccs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

>>> hw/rtl/c_comment_stripper_top.sv
// Top level of the C comment stripper: input register, scanner, two-entry result queue.
//
//  Channel  Dir  Payload                          Handshake
//  i_in     in   in_byte[7:0], end_of_stream      valid/ready
//  o_out    out  out_byte[7:0], last_of_run       valid/ready
//
// Flow: a byte is taken into the input register and scanned in the next cycle. Its
// results land in the result queue at the edge that consumes it, once the queue has room,
// and the head entry is offered on o_out. One byte per cycle is sustained while o_out
// takes results; a byte that yields two results ('/' then the byte) fills both queue
// entries, and the single output port drains them one at a time.
// Reset: synchronous, active low; clears the scan mode, input valid and queue.
// Stalls: o_out.ready low fills the two-entry queue, then holds the input register.
module c_comment_stripper_top
    import ccs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    ccs_in_if.sink     i_in,
    ccs_out_if.source  o_out
);

    // Scan mode codes
    localparam logic [2:0] MODE_NORMAL     = 3'd0;
    localparam logic [2:0] MODE_SLASH      = 3'd1;
    localparam logic [2:0] MODE_LINE       = 3'd2;
    localparam logic [2:0] MODE_LINE_ESC   = 3'd3;
    localparam logic [2:0] MODE_BLOCK      = 3'd4;
    localparam logic [2:0] MODE_BLOCK_STAR = 3'd5;

    // Input register
    logic       r_in_valid;
    t_item      r_in;

    // Scanner state
    logic [2:0] r_mode;
    logic [2:0] n_mode;

    // Result queue, entry 0 is the head
    t_result    r_q [2];
    t_result    n_q [2];
    logic [1:0] r_count;
    logic [1:0] n_count;

    // Scanner outputs for the byte in the input register
    logic [1:0] scan_num;
    t_result    scan_res0;
    t_result    scan_res1;
    logic [2:0] scan_mode;

    logic       pop;
    logic [1:0] cnt_after_pop;
    logic       consume;

    // Decode one byte against the current mode
    always_comb begin
        scan_num  = 2'd0;
        scan_res0 = '{out_byte: r_in.in_byte, last_of_run: 1'b1};
        scan_res1 = '{out_byte: r_in.in_byte, last_of_run: 1'b1};
        scan_mode = r_mode;
        unique case (r_mode)
            MODE_SLASH: begin
                if (r_in.in_byte == CH_SLASH) begin
                    scan_mode = MODE_LINE;
                end else if (r_in.in_byte == CH_STAR) begin
                    scan_mode = MODE_BLOCK;
                end else begin
                    // Release the held slash ahead of this byte
                    scan_res0 = '{out_byte: CH_SLASH, last_of_run: 1'b0};
                    scan_num  = 2'd2;
                    scan_mode = MODE_NORMAL;
                end
            end
            MODE_LINE: begin
                if (r_in.in_byte == CH_NEWLINE) begin
                    scan_num  = 2'd1;
                    scan_mode = MODE_NORMAL;
                end else if (r_in.in_byte == CH_BACKSLASH) begin
                    scan_mode = MODE_LINE_ESC;
                end
            end
            MODE_LINE_ESC: begin
                // Swallow the escaped byte, newline included
                scan_mode = MODE_LINE;
            end
            MODE_BLOCK: begin
                if (r_in.in_byte == CH_STAR) begin
                    scan_mode = MODE_BLOCK_STAR;
                end
            end
            MODE_BLOCK_STAR: begin
                if (r_in.in_byte == CH_SLASH) begin
                    scan_mode = MODE_NORMAL;
                end else if (r_in.in_byte != CH_STAR) begin
                    scan_mode = MODE_BLOCK;
                end
            end
            default: begin
                // Normal text, and the unused codes
                if (r_in.in_byte == CH_SLASH) begin
                    scan_mode = MODE_SLASH;
                end else begin
                    scan_num  = 2'd1;
                    scan_mode = MODE_NORMAL;
                end
            end
        endcase
        // End of stream closes any open comment and drops a slash still held after that byte
        if (r_in.end_of_stream) begin
            scan_mode = MODE_NORMAL;
        end
    end

    // Handshake: advance the input register only when the queue has room
    assign pop           = o_out.valid && o_out.ready;
    assign cnt_after_pop = r_count - {1'b0, pop};
    assign consume       = r_in_valid && ((2'd2 - cnt_after_pop) >= scan_num);
    assign i_in.ready    = !r_in_valid || consume;

    assign n_mode = consume ? scan_mode : r_mode;

    // Queue update: pop first, then append this transaction's results
    always_comb begin
        n_q[0]  = pop ? r_q[1] : r_q[0];
        n_q[1]  = r_q[1];
        n_count = cnt_after_pop;
        if (consume && scan_num != 2'd0) begin
            if (cnt_after_pop == 2'd0) begin
                n_q[0] = scan_res0;
                n_q[1] = scan_res1;
            end else begin
                n_q[1] = scan_res0;
            end
            n_count = cnt_after_pop + scan_num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_NORMAL;
            r_count    <= 2'd0;
        end else begin
            r_in_valid <= i_in.valid || (r_in_valid && !consume);
            r_mode     <= n_mode;
            r_count    <= n_count;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= '{in_byte: i_in.in_byte, end_of_stream: i_in.end_of_stream};
        end
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

    assign o_out.valid       = (r_count != 2'd0);
    assign o_out.out_byte    = r_q[0].out_byte;
    assign o_out.last_of_run = r_q[0].last_of_run;

    // Assertions
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("result queue overflow");

    a_eos_resets_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_in.end_of_stream) |=> (r_mode == MODE_NORMAL))
        else $error("mode not normal after end of stream");

    a_pair_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && scan_num == 2'd2) |=> (r_count == 2'd2))
        else $error("two-result transaction not fully queued");

    a_head_slash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != 2'd0 && !r_q[0].last_of_run) |-> (r_q[0].out_byte == CH_SLASH))
        else $error("non-final result is not a slash");

endmodule
